/* hdl/fmc_pkg.sv */
`default_nettype none

package fmc_pkg;

	localparam int unsigned WordWidth  = 16;
	localparam int unsigned StampWidth = 32;
	localparam int unsigned SumWidth   = 32;

	// Mixing constants: golden-ratio stamp multiplier and the murmur3 fmix32 set.
	localparam logic [31:0] Golden = 32'h9E37_79B9;
	localparam logic [31:0] MixC1  = 32'h85EB_CA6B;
	localparam logic [31:0] MixC2  = 32'hC2B2_AE35;
	localparam int unsigned MixS1  = 13;
	localparam int unsigned MixS2  = 16;

	// One accepted word as it travels from the front to the back.
	typedef struct packed {
		logic [StampWidth-1:0] stamp;
		logic                  last;
		logic [WordWidth-1:0]  word;
	} fmc_entry_t;

	// Handshake between a producer and the queue, and between the queue and a consumer.
	typedef struct packed {
		logic       valid;
		fmc_entry_t entry;
	} fmc_push_t;

	typedef struct packed {
		logic       full;
		logic       empty;
	} fmc_qstat_t;

endpackage

`default_nettype wire

/* hdl/fmc_front.sv */
`default_nettype none

module fmc_front
	import fmc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [WordWidth-1:0]  in_word,
	input  wire logic                  in_last,
	input  wire logic [StampWidth-1:0] in_stamp,
	input  wire fmc_qstat_t            qstat,
	output fmc_push_t                  push
);

	logic       valid_q;
	fmc_entry_t entry_q;
	logic       push_fire;

	assign push_fire = valid_q && !qstat.full;
	assign in_ready  = !valid_q || push_fire;

	assign push.valid = push_fire;
	assign push.entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// The stamp only matters on the last word, so it is dropped from the others.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			entry_q.word  <= in_word;
			entry_q.last  <= in_last;
			entry_q.stamp <= in_last ? in_stamp : '0;
		end
	end

endmodule

`default_nettype wire

/* hdl/fmc_queue.sv */
`default_nettype none

module fmc_queue
	import fmc_pkg::*;
#(
	parameter int unsigned Depth = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire fmc_push_t push,
	input  wire logic      pop,
	output fmc_entry_t     head,
	output fmc_qstat_t     qstat
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	fmc_entry_t      slot_q [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign qstat.full  = (count_q == CntW'(Depth));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push.valid && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push.entry;
		end
	end

endmodule

`default_nettype wire

/* hdl/fmc_back.sv */
`default_nettype none

module fmc_back
	import fmc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fmc_entry_t          head,
	input  wire fmc_qstat_t          qstat,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [SumWidth-1:0]      out_checksum
);

	logic                  advance;
	logic [WordWidth-1:0]  low_q;
	logic [WordWidth-1:0]  high_q;
	logic [WordWidth:0]    low_raw;
	logic [WordWidth-1:0]  low_new;
	logic [WordWidth:0]    high_raw;
	logic [WordWidth-1:0]  high_new;

	logic                  valid_s1, valid_s2, valid_s3, valid_s4;
	logic [31:0]           packed_s1, packed_s2;
	logic [StampWidth-1:0] stamp_s1;
	logic [31:0]           prod_s2;
	logic [31:0]           mix_s3;
	logic [31:0]           mix_s4;
	logic [31:0]           x2;
	logic [31:0]           x3;
	logic [31:0]           x4;
	logic                  out_valid_q;
	logic [31:0]           out_q;

	// The whole back end moves together; it stops only when a result is waiting.
	assign advance = !out_valid_q || out_ready;
	assign pop     = advance && !qstat.empty;

	// End-around carry: a carry out of bit 15 is added back in, 0xFFFF stays.
	assign low_raw  = {1'b0, low_q} + {1'b0, head.word};
	assign low_new  = low_raw[WordWidth-1:0] + {{(WordWidth-1){1'b0}}, low_raw[WordWidth]};
	assign high_raw = {1'b0, high_q} + {1'b0, low_new};
	assign high_new = high_raw[WordWidth-1:0] + {{(WordWidth-1){1'b0}}, high_raw[WordWidth]};

	assign x2 = packed_s2 ^ prod_s2;
	assign x3 = mix_s3 ^ (mix_s3 >> MixS1);
	assign x4 = mix_s4 ^ (mix_s4 >> MixS2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= '0;
			high_q      <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			if (pop) begin
				low_q  <= head.last ? '0 : low_new;
				high_q <= head.last ? '0 : high_new;
			end
			valid_s1    <= pop && head.last;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			packed_s1 <= {high_new, low_new};
			stamp_s1  <= head.stamp;
			packed_s2 <= packed_s1;
			prod_s2   <= 32'(stamp_s1 * Golden);
			mix_s3    <= 32'(x2 * MixC1);
			mix_s4    <= 32'(x3 * MixC2);
			out_q     <= x4;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_checksum = out_q;

endmodule

`default_nettype wire

/* hdl/fletcher32_mixed_checksum_core.sv */
`default_nettype none

// Mixed Fletcher-32 checksum core. A message enters as a stream of 16-bit words,
// first byte in the low bits, one word per item, with tlast set on the final word.
// Each word updates two 16-bit Fletcher sums with end-around carry folding: the
// low sum adds the word, then the high sum adds the new low sum. On the last word
// the sums are packed high:low, XORed with stamp times 0x9E3779B9, and run through
// the murmur3 fmix32 finalizer without its first shift-XOR: multiply, shift-XOR
// by 13, multiply, shift-XOR by 16; the result leaves on the master side as one
// item and both sums return to zero. Words that are not last produce no output,
// and their stamp is ignored. While no result is held, the core sustains one word
// per clock cycle: the input register and a four-entry queue absorb short stalls,
// and the back end folds one word per cycle. When nothing stalls, a last word goes
// from the input register into the queue, is folded on its way out, and passes
// the packing, stamp-product and two multiply registers into the output register.
// A held result stalls the back end, and the queue then fills before the slave
// side deasserts tready.
module fletcher32_mixed_checksum_core
	import fmc_pkg::*;
#(
	parameter int unsigned QueueDepth = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // word [15:0], stamp [47:16]
	input  wire logic        s_tlast,   // last word of the message
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // checksum [31:0]
);

	fmc_push_t  push;
	fmc_qstat_t qstat;
	fmc_entry_t head;
	logic       pop;

	// The front registers each accepted item and strips the stamp from inner words.
	fmc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_word  (s_tdata[15:0]),
		.in_last  (s_tlast),
		.in_stamp (s_tdata[47:16]),
		.qstat    (qstat),
		.push     (push)
	);

	// A short queue lets the front keep accepting while the back waits on its output.
	fmc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// The back holds the running sums and the finalizer pipeline.
	fmc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_checksum (m_tdata)
	);

endmodule

`default_nettype wire

/* verif/fletcher32_mixed_checksum_core_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the mixed Fletcher-32 checksum core.
// A short directed set of messages comes first. It covers all-zero and all-ones
// words and stamps, the end-around carry fold, a low sum that stays at 0xFFFF,
// and stamps on non-final words that the core must ignore. After that come random
// messages of random length. Both handshake sides idle at random, and the result
// side holds off once for a long stretch so that the core fills up and stalls its
// input. A monitor on each side feeds a small scoreboard that predicts every
// checksum and compares it against what the core produces.
module fletcher32_mixed_checksum_core_tb;
	import fmc_pkg::*;

	localparam int unsigned RandomWords = 2000;
	localparam int unsigned LongHold    = 300;
	localparam int unsigned DrainCycles = 24;
	// Longest correct silence is the long output hold plus the pipeline, so a
	// silence that reaches StallLimit means the core is stuck.
	localparam int unsigned StallLimit  = 3000;

	// Running Fletcher sums of the message in flight, and the checksums that the
	// core still owes, oldest first.
	class checksum_board;
		logic [WordWidth-1:0] low_acc;
		logic [WordWidth-1:0] high_acc;
		logic [SumWidth-1:0]  owed_sums[$];
		int                   errors;
		int                   checked;
		int                   words;
		int                   messages;

		function new();
			low_acc  = '0;
			high_acc = '0;
			errors   = 0;
			checked  = 0;
			words    = 0;
			messages = 0;
		endfunction

		// One end-around step is enough here, since both addends fit in 16 bits.
		// A result of 0xFFFF is left alone and is not turned into zero.
		function logic [WordWidth-1:0] fold(logic [WordWidth:0] s);
			return s[WordWidth] ? s[WordWidth-1:0] + 1'b1 : s[WordWidth-1:0];
		endfunction

		function logic [SumWidth-1:0] mix(logic [31:0] packed_sums, logic [StampWidth-1:0] stamp);
			logic [31:0] r;
			logic [31:0] salt;
			salt = stamp * Golden;
			r = packed_sums ^ salt;
			r = r * MixC1;
			r = r ^ (r >> MixS1);
			r = r * MixC2;
			r = r ^ (r >> MixS2);
			return r;
		endfunction

		function void note_word(logic [WordWidth-1:0] word, logic is_last,
			logic [StampWidth-1:0] stamp);
			words++;
			low_acc  = fold({1'b0, low_acc} + {1'b0, word});
			high_acc = fold({1'b0, high_acc} + {1'b0, low_acc});
			if (is_last) begin
				owed_sums.push_back(mix({high_acc, low_acc}, stamp));
				low_acc  = '0;
				high_acc = '0;
				messages++;
			end
		endfunction

		function void check_checksum(logic [SumWidth-1:0] actual);
			logic [SumWidth-1:0] want;
			if (owed_sums.size() == 0) begin
				errors++;
				$display("%0t: checksum %08h arrived with none expected", $time, actual);
			end else begin
				want = owed_sums.pop_front();
				checked++;
				if (actual !== want) begin
					errors++;
					$display("%0t: checksum mismatch, expected %08h, actual %08h",
						$time, want, actual);
				end
			end
		endfunction

		function int pending();
			return owed_sums.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // word [15:0], stamp [47:16]
	logic        s_tlast;   // last word of the message
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // checksum [31:0]

	checksum_board board;
	int unsigned   idle_cycles;

	fletcher32_mixed_checksum_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Every input starts at a known value. Reset is asserted once, at the start.
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		board    = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Both monitors sample at the rising edge, so they see the values that the
	// core registered at that edge, not the ones driven right after it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.note_word(s_tdata[15:0], s_tlast, s_tdata[47:16]);
			if (m_tvalid && m_tready)
				board.check_checksum(m_tdata);
		end
	end

	// The watchdog only counts cycles in which neither side moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= StallLimit) begin
				$display("%0t: no item moved for %0d cycles, %0d checksums still owed",
					$time, idle_cycles, board.pending());
				$display("FAIL");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

	// Offers one word after a random gap and returns once it is accepted. With a
	// zero gap tvalid stays high, so it is never dropped and raised in one step.
	task automatic send_word(input logic [15:0] word, input logic is_last,
		input logic [31:0] stamp, input bit eager);
		int gap;
		gap = eager ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {stamp, word};
		s_tlast  <= is_last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Biased toward the values that make the fold and the 0xFFFF case happen.
	function automatic logic [15:0] draw_word();
		case ($urandom_range(0, 7))
			0: return 16'hFFFF;
			1: return 16'h0000;
			2: return 16'hFFFF - 16'($urandom_range(0, 3));
			3: return 16'h8000 | 16'($urandom);
			default: return 16'($urandom);
		endcase
	endfunction

	// Result side. Stalls are drawn per checksum, with runs of full readiness
	// mixed in. After 60 checksums it holds off for a long stretch once, and the
	// sender keeps offering words, so the queue inside the core fills up.
	initial begin : result_sink
		int stall;
		int taken;
		bit eager;
		bit long_hold_done;
		taken          = 0;
		eager          = 1'b0;
		long_hold_done = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!long_hold_done && taken == 60) begin
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LongHold) @(posedge clk);
			end else begin
				if (taken % 40 == 0)
					eager = ($urandom_range(0, 3) == 0);
				stall = eager ? 0 : $urandom_range(0, 13);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			taken++;
		end
	end

	// Stimulus: directed messages, then random ones, then the drain and the verdict.
	initial begin : word_source
		int len;
		bit eager;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Single-word messages at both extremes of word and stamp.
		send_word(16'h0000, 1'b1, 32'h0000_0000, 1'b0);
		send_word(16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
		// All-ones words push both sums through the fold repeatedly.
		send_word(16'hFFFF, 1'b0, 32'h1234_5678, 1'b0);
		send_word(16'hFFFF, 1'b0, 32'hFFFF_FFFF, 1'b1);
		send_word(16'hFFFF, 1'b1, 32'hAAAA_AAAA, 1'b1);
		// Low sum reaches exactly 0x10000 and folds down to one.
		send_word(16'h8000, 1'b0, 32'hFFFF_FFFF, 1'b0);
		send_word(16'h8000, 1'b1, 32'h5555_5555, 1'b0);
		// Low sum lands on 0xFFFF and must stay there, while the high sum folds.
		send_word(16'h0001, 1'b0, 32'h0000_0000, 1'b0);
		send_word(16'hFFFE, 1'b1, 32'h8000_0000, 1'b0);
		// Alternating bit patterns, with a stamp on every non-final word that must
		// have no effect on the checksum.
		send_word(16'h5555, 1'b0, 32'hDEAD_BEEF, 1'b1);
		send_word(16'hAAAA, 1'b0, 32'h0F0F_0F0F, 1'b1);
		send_word(16'hFFFF, 1'b0, 32'hF0F0_F0F0, 1'b1);
		send_word(16'h0000, 1'b1, 32'h0000_0001, 1'b1);
		send_word(16'h1234, 1'b1, 32'h0000_0001, 1'b0);
		// The same words again, differing only in the ignored stamps.
		send_word(16'h5555, 1'b0, 32'h0000_0000, 1'b0);
		send_word(16'hAAAA, 1'b0, 32'hFFFF_FFFF, 1'b0);
		send_word(16'hFFFF, 1'b0, 32'h1111_1111, 1'b0);
		send_word(16'h0000, 1'b1, 32'h0000_0001, 1'b0);

		// Random messages, mostly short ones with a few long ones. Every word
		// carries a random stamp, even where the core should ignore it.
		while (board.words < RandomWords) begin
			eager = ($urandom_range(0, 4) == 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			for (int k = 0; k < len; k++)
				send_word(draw_word(), k == len - 1, $urandom(), eager);
		end
		s_tvalid <= 1'b0;

		// Wait for every owed checksum, then give the pipeline time to show any
		// extra result. The watchdog ends the run if something never arrives.
		while (board.pending() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d words in %0d messages and checked %0d checksums,",
			board.words, board.messages, board.checked);
		$display("with random idling on both sides and one %0d-cycle output hold.", LongHold);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
